### rtl/pfa_pkg.sv
package pfa_pkg;

    localparam int DEF_NUM_PARTITIONS = 8;
    localparam int DEF_SIZE_BITS      = 16;

    localparam int KIND_W   = 2;
    localparam int IN_IDX_W = 3;
    localparam int FIELD_W  = 16;

    localparam int IDX_MAX_W = 6;
    localparam int VAL_W     = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic                 valid;
        op_t                  op;
        logic [1:0]           policy;
        logic [IDX_MAX_W-1:0] target;
        logic [VAL_W-1:0]     want;
        logic                 found;
        logic [IDX_MAX_W-1:0] idx;
        logic [VAL_W-1:0]     left;
        logic [VAL_W-1:0]     size;
        logic [VAL_W-1:0]     offset;
    } pfa_tok_t;

    typedef struct packed {
        logic load;
        logic take;
        logic release_part;
    } pfa_ctl_t;

endpackage

### rtl/pfa_cell.sv
module pfa_cell
    import pfa_pkg::*;
#(
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int CELL_IDX  = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pfa_ctl_t         ctl,
    input  logic [VAL_W-1:0] load_offset,
    input  logic [VAL_W-1:0] load_size,
    input  pfa_tok_t         tok_in,
    output pfa_tok_t         tok_out
);

    logic [SIZE_BITS-1:0] offset_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 present_reg;
    logic                 taken_reg;
    pfa_tok_t             tok_reg;
    pfa_tok_t             tok_next;

    logic [VAL_W-1:0] size_ext;
    logic [VAL_W-1:0] left;
    logic             fits;
    logic             better;
    logic             take_tok;

    always_comb
    begin
        size_ext = VAL_W'(size_reg);
        left     = size_ext - tok_in.want;
        fits     = present_reg && !taken_reg && (size_ext >= tok_in.want);
        better   = !tok_in.found
                || ((tok_in.policy == FIT_BEST)  && (left < tok_in.left))
                || ((tok_in.policy == FIT_WORST) && (left > tok_in.left));
        if (tok_in.op == OP_ALLOC)
        begin
            take_tok = fits && better;
        end
        else
        begin
            take_tok = present_reg && (tok_in.target == IDX_MAX_W'(CELL_IDX));
        end
        tok_next = tok_in;
        if (tok_in.valid && take_tok)
        begin
            tok_next.found  = 1'b1;
            tok_next.idx    = IDX_MAX_W'(CELL_IDX);
            tok_next.left   = left;
            tok_next.size   = size_ext;
            tok_next.offset = VAL_W'(offset_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            taken_reg   <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (ctl.load)
            begin
                present_reg <= 1'b1;
                taken_reg   <= 1'b0;
            end
            else if (ctl.take)
            begin
                taken_reg <= 1'b1;
            end
            else if (ctl.release_part)
            begin
                taken_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            offset_reg <= load_offset[SIZE_BITS-1:0];
            size_reg   <= load_size[SIZE_BITS-1:0];
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/partition_fit_allocator_top.sv
// Partition table of NUM_PARTITIONS entries, one per cell in a chain. A load is
// written at the transfer and its result is registered in the pending registers,
// then moved to the output register. An allocate or free sends a search token
// down the chain, one cell per cycle; when it leaves the last cell its result is
// registered in the pending registers and then moved to the output register. The
// allocated mark is updated as the result enters the output register. One item is
// in work at a time; a new item is taken once the previous result has moved to the
// output register, so a result held at the output stalls the next one. The policy
// register takes a write every cycle.
module partition_fit_allocator_top
    import pfa_pkg::*;
#(
    parameter int NUM_PARTITIONS = DEF_NUM_PARTITIONS,
    parameter int SIZE_BITS      = DEF_SIZE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [IN_IDX_W-1:0] partition_index,
    input  logic [FIELD_W-1:0]  partition_offset,
    input  logic [FIELD_W-1:0]  request_size,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                success,
    output logic [IN_IDX_W-1:0] chosen_index,
    output logic [FIELD_W-1:0]  chosen_size,
    output logic [FIELD_W-1:0]  chosen_offset
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam logic [VAL_W-1:0] SIZE_MASK = VAL_W'((64'd1 << SIZE_BITS) - 64'd1);

    state_t               state_reg;
    logic [1:0]           policy_reg;
    logic                 out_valid_reg;
    logic                 success_reg;
    logic [IN_IDX_W-1:0]  index_reg;
    logic [FIELD_W-1:0]   size_reg;
    logic [FIELD_W-1:0]   offset_reg;
    logic                 pend_success_reg;
    logic [IN_IDX_W-1:0]  pend_index_reg;
    logic [FIELD_W-1:0]   pend_size_reg;
    logic [FIELD_W-1:0]   pend_offset_reg;
    logic                 upd_valid_reg;
    op_t                  upd_op_reg;
    logic [IDX_MAX_W-1:0] upd_idx_reg;

    logic             in_fire;
    logic             done_move;
    logic             idx_ok;
    logic [VAL_W-1:0] ld_offset;
    logic [VAL_W-1:0] ld_size;

    pfa_tok_t tok_chain [0:NUM_PARTITIONS];
    pfa_ctl_t cell_ctl  [0:NUM_PARTITIONS-1];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign done_move = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign idx_ok    = (32'(partition_index) < NUM_PARTITIONS);
    assign ld_offset = VAL_W'(partition_offset) & SIZE_MASK;
    assign ld_size   = VAL_W'(request_size) & SIZE_MASK;

    always_comb
    begin
        tok_chain[0]        = '0;
        tok_chain[0].valid  = in_fire && ((kind == KIND_ALLOC) || (kind == KIND_FREE));
        tok_chain[0].op     = (kind == KIND_FREE) ? OP_FREE : OP_ALLOC;
        tok_chain[0].policy = policy_reg;
        tok_chain[0].target = IDX_MAX_W'(partition_index);
        tok_chain[0].want   = VAL_W'(request_size);
    end

    for (genvar i = 0; i < NUM_PARTITIONS; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctl[i].load = in_fire && (kind == KIND_LOAD)
                             && (32'(partition_index) == i);
            cell_ctl[i].take = done_move && upd_valid_reg && (upd_op_reg == OP_ALLOC)
                             && (upd_idx_reg == IDX_MAX_W'(i));
            cell_ctl[i].release_part = done_move && upd_valid_reg
                                     && (upd_op_reg == OP_FREE)
                                     && (upd_idx_reg == IDX_MAX_W'(i));
        end

        pfa_cell #(
            .SIZE_BITS (SIZE_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl[i]),
            .load_offset (ld_offset),
            .load_size   (ld_size),
            .tok_in      (tok_chain[i]),
            .tok_out     (tok_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            policy_reg       <= FIT_FIRST;
            out_valid_reg    <= 1'b0;
            success_reg      <= 1'b0;
            index_reg        <= '0;
            size_reg         <= '0;
            offset_reg       <= '0;
            pend_success_reg <= 1'b0;
            pend_index_reg   <= '0;
            pend_size_reg    <= '0;
            pend_offset_reg  <= '0;
            upd_valid_reg    <= 1'b0;
            upd_op_reg       <= OP_ALLOC;
            upd_idx_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready && !done_move)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        upd_valid_reg <= 1'b0;
                        if ((kind == KIND_ALLOC) || (kind == KIND_FREE))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                            if ((kind == KIND_LOAD) && idx_ok)
                            begin
                                pend_success_reg <= 1'b1;
                                pend_index_reg   <= partition_index;
                                pend_size_reg    <= ld_size[FIELD_W-1:0];
                                pend_offset_reg  <= ld_offset[FIELD_W-1:0];
                            end
                            else
                            begin
                                pend_success_reg <= 1'b0;
                                pend_index_reg   <= '0;
                                pend_size_reg    <= '0;
                                pend_offset_reg  <= '0;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (tok_chain[NUM_PARTITIONS].valid)
                    begin
                        state_reg     <= ST_DONE;
                        upd_valid_reg <= tok_chain[NUM_PARTITIONS].found;
                        upd_op_reg    <= tok_chain[NUM_PARTITIONS].op;
                        upd_idx_reg   <= tok_chain[NUM_PARTITIONS].idx;
                        if (tok_chain[NUM_PARTITIONS].found)
                        begin
                            pend_success_reg <= 1'b1;
                            pend_index_reg   <= tok_chain[NUM_PARTITIONS].idx[IN_IDX_W-1:0];
                            pend_size_reg    <= tok_chain[NUM_PARTITIONS].size[FIELD_W-1:0];
                            pend_offset_reg  <= tok_chain[NUM_PARTITIONS].offset[FIELD_W-1:0];
                        end
                        else
                        begin
                            pend_success_reg <= 1'b0;
                            pend_index_reg   <= '0;
                            pend_size_reg    <= '0;
                            pend_offset_reg  <= '0;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (done_move)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        success_reg   <= pend_success_reg;
                        index_reg     <= pend_index_reg;
                        size_reg      <= pend_size_reg;
                        offset_reg    <= pend_offset_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign success       = success_reg;
    assign chosen_index  = index_reg;
    assign chosen_size   = size_reg;
    assign chosen_offset = offset_reg;

endmodule

### sim/partition_fit_allocator_top_test.sv
module partition_fit_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int PARTS = DEF_NUM_PARTITIONS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENT_ITEMS = 84;
    localparam logic [1:0] FIT_SPARE = 2'd3;

    typedef struct packed {
        logic                 success;
        logic [IN_IDX_W-1:0]  index;
        logic [FIELD_W-1:0]   size;
        logic [FIELD_W-1:0]   offset;
    } grant_t;

    class partition_grant_predictor;
        logic [FIELD_W-1:0] offsets [PARTS];
        logic [FIELD_W-1:0] sizes [PARTS];
        bit                 present [PARTS];
        bit                 taken [PARTS];
        logic [1:0]         policy;
        grant_t             grants_due [$];
        int                 errors;

        function new();
            for (int i = 0; i < PARTS; i++)
            begin
                offsets[i] = '0;
                sizes[i] = '0;
                present[i] = 1'b0;
                taken[i] = 1'b0;
            end
            policy = FIT_FIRST;
            errors = 0;
        endfunction

        function int pick_partition(logic [FIELD_W-1:0] want);
            int chosen;
            logic [FIELD_W-1:0] chosen_left;
            logic [FIELD_W-1:0] left;
            chosen = -1;
            chosen_left = '0;
            for (int i = 0; i < PARTS; i++)
            begin
                if (!present[i] || taken[i] || sizes[i] < want)
                    continue;
                left = sizes[i] - want;
                if (chosen < 0)
                begin
                    chosen = i;
                    chosen_left = left;
                    if (policy != FIT_BEST && policy != FIT_WORST)
                        break;
                end
                else if (policy == FIT_BEST && left < chosen_left)
                begin
                    chosen = i;
                    chosen_left = left;
                end
                else if (policy == FIT_WORST && left > chosen_left)
                begin
                    chosen = i;
                    chosen_left = left;
                end
            end
            return chosen;
        endfunction

        function grant_t granted(int idx);
            grant_t g;
            g.success = 1'b1;
            g.index = IN_IDX_W'(idx);
            g.size = sizes[idx];
            g.offset = offsets[idx];
            return g;
        endfunction

        function void note_request(kind_t k, logic [IN_IDX_W-1:0] idx,
                                   logic [FIELD_W-1:0] off, logic [FIELD_W-1:0] size);
            grant_t g;
            int c;
            g = '0;
            case (k)
                KIND_LOAD:
                begin
                    offsets[idx] = off;
                    sizes[idx] = size;
                    present[idx] = 1'b1;
                    taken[idx] = 1'b0;
                    g = granted(idx);
                end
                KIND_ALLOC:
                begin
                    c = pick_partition(size);
                    if (c >= 0)
                    begin
                        taken[c] = 1'b1;
                        g = granted(c);
                    end
                end
                KIND_FREE:
                begin
                    if (present[idx])
                    begin
                        taken[idx] = 1'b0;
                        g = granted(idx);
                    end
                end
                default: g = '0;
            endcase
            grants_due.push_back(g);
        endfunction

        function void check_grant(grant_t got);
            grant_t want;
            if (grants_due.size() == 0)
            begin
                $error("unexpected result: success %0d index %0d size %0d offset %0d",
                       got.success, got.index, got.size, got.offset);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            if (got.success !== want.success)
            begin
                $error("success: expected %0d, got %0d", want.success, got.success);
                errors++;
            end
            if (got.index !== want.index)
            begin
                $error("chosen_index: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.size !== want.size)
            begin
                $error("chosen_size: expected %0d, got %0d", want.size, got.size);
                errors++;
            end
            if (got.offset !== want.offset)
            begin
                $error("chosen_offset: expected %0d, got %0d", want.offset, got.offset);
                errors++;
            end
        endfunction

        function int pending();
            return grants_due.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind = '0;
    logic [IN_IDX_W-1:0] partition_index = '0;
    logic [FIELD_W-1:0]  partition_offset = '0;
    logic [FIELD_W-1:0]  request_size = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                success;
    logic [IN_IDX_W-1:0] chosen_index;
    logic [FIELD_W-1:0]  chosen_size;
    logic [FIELD_W-1:0]  chosen_offset;

    partition_grant_predictor grants = new();

    int send_idle_pct = 9;
    int recv_idle_pct = 88;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    partition_fit_allocator_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .partition_index  (partition_index),
        .partition_offset (partition_offset),
        .request_size     (request_size),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .success          (success),
        .chosen_index     (chosen_index),
        .chosen_size      (chosen_size),
        .chosen_offset    (chosen_offset)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            grants.check_grant(grant_t'({success, chosen_index, chosen_size, chosen_offset}));
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(kind_t k, logic [IN_IDX_W-1:0] idx,
                             logic [FIELD_W-1:0] off, logic [FIELD_W-1:0] size);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        kind <= k;
        partition_index <= idx;
        partition_offset <= off;
        request_size <= size;
        do
            @(posedge clk);
        while (!in_ready);
        grants.note_request(k, idx, off, size);
    endtask

    // hold input low until every outstanding result has arrived
    task automatic drain();
        in_valid <= 1'b0;
        while (grants.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] p);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= p;
        do
            @(posedge clk);
        while (!cfg_ready);
        grants.policy = p;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] next_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return FIELD_W'($urandom_range(0, 1023));
        if (r < 85)
            return FIELD_W'($urandom);
        return r[0] ? '1 : '0;
    endfunction

    task automatic run_random(int n);
        int r;
        kind_t k;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                k = KIND_LOAD;
            else if (r < 70)
                k = KIND_ALLOC;
            else if (r < 95)
                k = KIND_FREE;
            else
                k = KIND_NOP;
            send_item(k, IN_IDX_W'($urandom_range(0, PARTS - 1)), FIELD_W'($urandom),
                      next_size());
        end
    endtask

    initial
    begin
        logic [1:0] fit_order [4];
        fit_order = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_SPARE};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'h0000);
        send_item(KIND_FREE, 3'd5, 16'hFFFF, 16'hFFFF);
        send_item(KIND_NOP, 3'd7, 16'hFFFF, 16'hFFFF);
        send_item(KIND_LOAD, 3'd0, 16'h0000, 16'h0000);
        send_item(KIND_LOAD, 3'd7, 16'hFFFF, 16'hFFFF);
        send_item(KIND_LOAD, 3'd1, 16'h1000, 16'd100);
        send_item(KIND_LOAD, 3'd2, 16'h2000, 16'd50);
        send_item(KIND_LOAD, 3'd3, 16'h3000, 16'd300);
        send_item(KIND_LOAD, 3'd4, 16'h4000, 16'd50);
        send_item(KIND_LOAD, 3'd5, 16'h5000, 16'd1000);
        send_item(KIND_LOAD, 3'd6, 16'h6000, 16'd20);
        send_item(KIND_ALLOC, 3'd3, 16'h0000, 16'd0);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'hFFFF);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'hFFFF);
        send_item(KIND_FREE, 3'd7, 16'h0000, 16'h0000);
        send_item(KIND_FREE, 3'd7, 16'h0000, 16'h0000);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'd60);
        write_policy(FIT_BEST);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'd50);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'd50);
        write_policy(FIT_WORST);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'd10);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'd10);
        write_policy(FIT_SPARE);
        send_item(KIND_ALLOC, 3'd0, 16'h0000, 16'd10);
        send_item(KIND_FREE, 3'd3, 16'h0000, 16'h0000);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 9 : 0;
            for (int p = 0; p < 4; p++)
            begin
                write_policy(fit_order[p]);
                if (ph == 2 && p == 1)
                    hold_reqs <= hold_reqs + 1;
                run_random(SEGMENT_ITEMS);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (grants.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
